>>> hw/rtl/bfiq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfiq_pkg;

    // store geometry
    localparam int unsigned FILTER_BITS = 65536;
    localparam int unsigned MAX_PROBES  = 16;
    localparam int unsigned ROW_BITS    = 64;
    localparam int unsigned ROW_COUNT   = FILTER_BITS / ROW_BITS;
    localparam int unsigned ROW_AW      = $clog2(ROW_COUNT);
    localparam int unsigned COL_AW      = $clog2(ROW_BITS);
    localparam int unsigned POS_W       = ROW_AW + COL_AW;

    // field and register widths
    localparam int unsigned HASH_W  = 64;
    localparam int unsigned SIZE_W  = 17;
    localparam int unsigned PROBE_W = 5;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CFG_W   = 17;

    // divider: bits retired per cycle and cycle count
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned DIV_CYCLES = HASH_W / DIV_BITS;
    localparam int unsigned DCNT_W     = $clog2(DIV_CYCLES);

    // size limits
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(FILTER_BITS);

    // item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // register indexes
    localparam logic CFG_SIZE   = 1'b0;
    localparam logic CFG_PROBES = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic rd;
        logic upd;
        logic clr_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       div_last;
        logic       last_probe;
        logic       clr_last;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/bloom_filter_insert_query_unit.sv
// operation: insert and query run each probe through the radix-16 remainder unit,
//   one store read and one read-modify-write; after its last probe a query loads
//   its result word once the output is free; a clear zeroes the store one row a cycle
// throughput: one word at a time, set by the shared remainder unit
// reset: synchronous active-low; a clearing pass zeroes the store
//   before the first word is accepted; registers reset to 64 bits, 3 probes
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_insert_query_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [bfiq_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_kind,
    input  wire logic [bfiq_pkg::HASH_W-1:0] s_key_hash,
    input  wire logic                        s_start_group,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_hit,
    output logic                             m_group_hit
);
    import bfiq_pkg::*;

    cmd_t    cmd;
    status_t status;

    bfiq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .status  (status),
        .cmd     (cmd)
    );

    bfiq_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_kind        (s_kind),
        .s_key_hash    (s_key_hash),
        .s_start_group (s_start_group),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_group_hit   (m_group_hit)
    );

endmodule
`default_nettype wire

>>> hw/rtl/bfiq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bfiq_datapath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire bfiq_pkg::cmd_t             cmd,
    output bfiq_pkg::status_t               status,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_index,
    input  wire logic [bfiq_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic [1:0]                 s_kind,
    input  wire logic [bfiq_pkg::HASH_W-1:0] s_key_hash,
    input  wire logic                       s_start_group,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_hit,
    output logic                            m_group_hit
);
    import bfiq_pkg::*;

    logic [SIZE_W-1:0]  size_cfg_reg;
    logic [PROBE_W-1:0] probe_cfg_reg;

    logic [1:0]         kind_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic               start_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [PROBE_W-1:0] probes_reg;
    logic [HASH_W-1:0]  h_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [HASH_W-1:0]  dvd_reg;
    logic [POS_W-1:0]   rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [ROW_AW-1:0]  clr_reg;
    logic [ROW_BITS-1:0] rdata_reg;
    logic               group_reg;
    logic               m_valid_reg;
    logic               may_reg;
    logic               all_reg;

    logic [ROW_BITS-1:0] mem [ROW_COUNT];

    logic [SIZE_W-1:0]  size_eff;
    logic [SIZE_W-1:0]  size_tmp;
    logic [PROBE_W-1:0] probes_eff;
    logic [POS_W+1:0]   rem_next;
    logic [HASH_W-1:0]  h_next;
    logic [ROW_AW-1:0]  row_addr;
    logic [COL_AW-1:0]  col_addr;
    logic               probe_bit;
    logic               all_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg  <= SIZE_MIN;
            probe_cfg_reg <= PROBE_W'(3);
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_SIZE) begin
                size_cfg_reg <= cfg_wdata;
            end else begin
                probe_cfg_reg <= cfg_wdata[PROBE_W-1:0];
            end
        end
    end

    // clamp size (rounded down to a multiple of 8) and probe count
    always_comb begin
        size_tmp = (size_cfg_reg > SIZE_MAX) ? SIZE_MAX : size_cfg_reg;
        size_tmp = {size_tmp[SIZE_W-1:3], 3'b000};
        size_eff = (size_tmp < SIZE_MIN) ? SIZE_MIN : size_tmp;
        if (probe_cfg_reg == '0) begin
            probes_eff = PROBE_W'(1);
        end else if (probe_cfg_reg > PROBE_W'(MAX_PROBES)) begin
            probes_eff = PROBE_W'(MAX_PROBES);
        end else begin
            probes_eff = probe_cfg_reg;
        end
    end

    // radix-16 restoring remainder step
    always_comb begin
        rem_next = {2'b00, rem_reg};
        for (int j = 0; j < DIV_BITS; j++) begin
            rem_next = {rem_next[POS_W:0], dvd_reg[HASH_W-1-j]};
            if (rem_next >= (POS_W+2)'(size_reg)) begin
                rem_next = rem_next - (POS_W+2)'(size_reg);
            end
        end
    end

    // next probe base: add (hash >> 16) and 2i+1
    assign h_next = h_reg + {16'b0, hash_reg[HASH_W-1:16]}
                  + {{(HASH_W-IDX_W-1){1'b0}}, idx_reg, 1'b1};

    assign row_addr  = rem_reg[POS_W-1:COL_AW];
    assign col_addr  = rem_reg[COL_AW-1:0];
    assign probe_bit = rdata_reg[col_addr];
    assign all_next  = start_reg ? hit_reg : (group_reg & hit_reg);

    // item and probe sequencing registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_kind;
            hash_reg   <= s_key_hash;
            start_reg  <= s_start_group;
            size_reg   <= size_eff;
            probes_reg <= probes_eff;
            h_reg      <= s_key_hash;
            idx_reg    <= '0;
            hit_reg    <= 1'b1;
            dvd_reg    <= s_key_hash;
            rem_reg    <= '0;
            dcnt_reg   <= '0;
        end else if (cmd.div_step) begin
            dvd_reg  <= {dvd_reg[HASH_W-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
            rem_reg  <= rem_next[POS_W-1:0];
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end else if (cmd.upd) begin
            if (kind_reg == KIND_QUERY) begin
                hit_reg <= hit_reg & probe_bit;
            end
            h_reg    <= h_next;
            idx_reg  <= idx_reg + IDX_W'(1);
            dvd_reg  <= h_next;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
    end

    // clear sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_reg <= clr_reg + ROW_AW'(1);
        end
    end

    // filter bit store
    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            mem[clr_reg] <= '0;
        end else if (cmd.upd && kind_reg == KIND_INSERT) begin
            mem[row_addr] <= rdata_reg | (ROW_BITS'(1) << col_addr);
        end
        if (cmd.rd) begin
            rdata_reg <= mem[row_addr];
        end
    end

    // result word and group accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            group_reg   <= 1'b1;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
                group_reg   <= all_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            may_reg <= hit_reg;
            all_reg <= all_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = may_reg;
    assign m_group_hit = all_reg;

    assign status.kind       = kind_reg;
    assign status.div_last   = (dcnt_reg == DCNT_W'(DIV_CYCLES - 1));
    assign status.last_probe = (({1'b0, idx_reg} + PROBE_W'(1)) == probes_reg);
    assign status.clr_last   = (clr_reg == ROW_AW'(ROW_COUNT - 1));
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule
`default_nettype wire

>>> hw/rtl/bfiq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bfiq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_kind,
    input  wire bfiq_pkg::status_t status,
    output bfiq_pkg::cmd_t         cmd
);
    import bfiq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_kind)
                        KIND_CLEAR:  state_next = ST_CLEAR;
                        KIND_INSERT: state_next = ST_DIV;
                        KIND_QUERY:  state_next = ST_DIV;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                if (status.div_last) state_next = ST_READ;
            end
            ST_READ: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (!status.last_probe) begin
                    state_next = ST_DIV;
                end else if (status.kind == KIND_QUERY) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:  cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIV:    cmd.div_step = 1'b1;
            ST_READ:   cmd.rd = 1'b1;
            ST_UPDATE: cmd.upd = 1'b1;
            ST_OUT:    cmd.out_load = status.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule
`default_nettype wire
